// ===== hw/rtl/nmt_pkg.sv =====
// Package for the NAT mapping table: widths, codes and defaults.
package nmt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    // Operation codes
    localparam logic [1:0] MODE_LKP_IN  = 2'd0;
    localparam logic [1:0] MODE_LKP_OUT = 2'd1;
    localparam logic [1:0] MODE_INSERT  = 2'd2;
    localparam logic [1:0] MODE_TICK    = 2'd3;

    // Status codes
    localparam logic [2:0] ST_MISS     = 3'd0;
    localparam logic [2:0] ST_HIT      = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_TICK     = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_ICMP_LIMIT = 2'd0;
    localparam logic [1:0] REG_TCP_LIMIT  = 2'd1;
    localparam logic [1:0] REG_ICMP_BASE  = 2'd2;
    localparam logic [1:0] REG_TCP_BASE   = 2'd3;

    localparam logic [15:0] ICMP_LIMIT_RST = 16'd60;
    localparam logic [15:0] TCP_LIMIT_RST  = 16'd7440;
    localparam logic [15:0] ICMP_BASE_RST  = 16'd1024;
    localparam logic [15:0] TCP_BASE_RST   = 16'd1024;

    localparam int ENTRY_W = 1 + 32 + 16 + 16 + 32 + 32;

    // One stored mapping
    typedef struct packed {
        logic        proto;
        logic [31:0] addr;
        logic [15:0] iport;
        logic [15:0] oport;
        logic [31:0] last_seen;
        logic [31:0] serial;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic start;     // latch request, clear scan results
        logic rd_en;     // read entry at scan index
        logic commit;    // apply operation result
        logic out_load;  // load result register
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last; // read index is at the last slot
    } dp_stat_t;

endpackage

// ===== hw/rtl/nmt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module nmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/nmt_ctrl.sv =====
// Controller state machine sequencing the slot scan of one transaction.
module nmt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  nmt_pkg::dp_stat_t stat,
    output nmt_pkg::ctl_cmd_t cmd
);
    import nmt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       accept;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // last entry read is evaluated in this cycle
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !accept)
        else $error("accepted while busy");
    a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_SCAN))
        else $error("start did not begin scan");
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result not presented");
`endif
endmodule

// ===== hw/rtl/nmt_dp.sv =====
// Datapath: entry store, scan evaluation, counters and result register.
module nmt_dp #(
    parameter int TABLE_DEPTH = nmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nmt_pkg::ctl_cmd_t cmd,
    output nmt_pkg::dp_stat_t stat,
    input  logic [1:0]        mode,
    input  logic              proto,
    input  logic [31:0]       inside_addr,
    input  logic [15:0]       inside_port,
    input  logic [15:0]       outside_port,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_idx,
    input  logic [15:0]       cfg_data,
    output logic [31:0]       cfg_rdata,
    output logic [2:0]        status,
    output logic              found_proto,
    output logic [31:0]       found_addr,
    output logic [15:0]       found_inside_port,
    output logic [15:0]       found_outside_port,
    output logic [6:0]        expired_count
);
    import nmt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    // Configuration registers
    logic [15:0] icmp_lim_reg, tcp_lim_reg, icmp_base_reg, tcp_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icmp_lim_reg  <= ICMP_LIMIT_RST;
            tcp_lim_reg   <= TCP_LIMIT_RST;
            icmp_base_reg <= ICMP_BASE_RST;
            tcp_base_reg  <= TCP_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ICMP_LIMIT: icmp_lim_reg  <= cfg_data;
                REG_TCP_LIMIT:  tcp_lim_reg   <= cfg_data;
                REG_ICMP_BASE:  icmp_base_reg <= cfg_data;
                REG_TCP_BASE:   tcp_base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ICMP_LIMIT: cfg_rdata = {16'd0, icmp_lim_reg};
            REG_TCP_LIMIT:  cfg_rdata = {16'd0, tcp_lim_reg};
            REG_ICMP_BASE:  cfg_rdata = {16'd0, icmp_base_reg};
            REG_TCP_BASE:   cfg_rdata = {16'd0, tcp_base_reg};
            default:        cfg_rdata = '0;
        endcase
    end

    // Latched request
    logic [1:0]  mode_reg;
    logic        proto_reg;
    logic [31:0] addr_reg;
    logic [15:0] iport_reg, oport_reg;

    // Scan state
    logic [IW-1:0] rd_idx_reg, ev_idx_reg;
    logic          ev_vld_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic          best_vld_reg, free_vld_reg;
    logic [IW-1:0] best_idx_reg, free_idx_reg;
    logic [31:0]   best_age_reg;
    entry_t        best_ent_reg;
    logic [6:0]    freed_reg;

    // Global counters
    logic [31:0] now_reg, serial_reg;
    logic [15:0] icmp_cnt_reg, tcp_cnt_reg;

    // Entry store
    entry_t ram_rdata, ram_wdata;
    logic   ram_we;
    logic [IW-1:0] ram_waddr;

    nmt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign stat.scan_last = (rd_idx_reg == LAST_IDX);

    // Per-entry evaluation of the word read last cycle
    logic        ev_valid, ev_match, ev_better, ev_exp;
    logic [31:0] ev_age, ev_idle;
    logic [15:0] ev_limit;
    logic        do_eval;

    assign do_eval = ev_vld_reg;

    always_comb
    begin
        ev_valid = valid_reg[ev_idx_reg];
        ev_age   = serial_reg - ram_rdata.serial;
        ev_idle  = now_reg - ram_rdata.last_seen;
        ev_limit = ram_rdata.proto ? tcp_lim_reg : icmp_lim_reg;
        ev_exp   = ev_valid && (ev_idle > {16'd0, ev_limit});
        if (mode_reg == MODE_LKP_IN)
        begin
            ev_match = ev_valid && (ram_rdata.proto == proto_reg)
                && (ram_rdata.addr == addr_reg) && (ram_rdata.iport == iport_reg);
        end
        else
        begin
            ev_match = ev_valid && (ram_rdata.proto == proto_reg)
                && (ram_rdata.oport == oport_reg);
        end
        ev_better = ev_match && (!best_vld_reg || ev_age < best_age_reg);
    end

    // Scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg   <= '0;
            ev_idx_reg   <= '0;
            ev_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            free_vld_reg <= 1'b0;
            freed_reg    <= '0;
        end
        else
        begin
            ev_vld_reg <= cmd.rd_en;
            ev_idx_reg <= rd_idx_reg;
            if (cmd.start)
            begin
                rd_idx_reg   <= '0;
                best_vld_reg <= 1'b0;
                free_vld_reg <= 1'b0;
                freed_reg    <= '0;
            end
            else
            begin
                if (cmd.rd_en)
                begin
                    rd_idx_reg <= stat.scan_last ? '0 : rd_idx_reg + 1'b1;
                end
                if (do_eval)
                begin
                    if (ev_better)
                    begin
                        best_vld_reg <= 1'b1;
                        best_age_reg <= ev_age;
                        best_idx_reg <= ev_idx_reg;
                        best_ent_reg <= ram_rdata;
                    end
                    if (!ev_valid && !free_vld_reg)
                    begin
                        free_vld_reg <= 1'b1;
                        free_idx_reg <= ev_idx_reg;
                    end
                    if (ev_exp && freed_reg != 7'd127)
                    begin
                        freed_reg <= freed_reg + 7'd1;
                    end
                end
            end
        end
    end

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg  <= mode;
            proto_reg <= proto;
            addr_reg  <= inside_addr;
            iport_reg <= inside_port;
            oport_reg <= outside_port;
        end
    end

    // Commit: write-back and global state
    logic [15:0] new_oport;
    logic        is_lkp, do_hit, do_ins;

    assign is_lkp    = (mode_reg == MODE_LKP_IN) || (mode_reg == MODE_LKP_OUT);
    assign do_hit    = cmd.commit && is_lkp && best_vld_reg;
    assign do_ins    = cmd.commit && (mode_reg == MODE_INSERT) && free_vld_reg;
    assign new_oport = proto_reg ? (tcp_base_reg + tcp_cnt_reg)
                                 : (icmp_base_reg + icmp_cnt_reg);

    always_comb
    begin
        ram_we    = do_hit || do_ins;
        ram_waddr = do_ins ? free_idx_reg : best_idx_reg;
        ram_wdata = best_ent_reg;
        ram_wdata.last_seen = now_reg;
        if (do_ins)
        begin
            ram_wdata.proto  = proto_reg;
            ram_wdata.addr   = addr_reg;
            ram_wdata.iport  = iport_reg;
            ram_wdata.oport  = new_oport;
            ram_wdata.serial = serial_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            now_reg      <= '0;
            serial_reg   <= '0;
            icmp_cnt_reg <= '0;
            tcp_cnt_reg  <= '0;
        end
        else
        begin
            // the tick advances time before its scan starts
            if (cmd.start && mode == MODE_TICK)
            begin
                now_reg <= now_reg + 32'd1;
            end
            // a tick frees each idle entry as the scan passes it
            if (do_eval && mode_reg == MODE_TICK && ev_exp)
            begin
                valid_reg[ev_idx_reg] <= 1'b0;
            end
            if (do_ins)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                serial_reg <= serial_reg + 32'd1;
                if (proto_reg)
                begin
                    tcp_cnt_reg <= tcp_cnt_reg + 16'd1;
                end
                else
                begin
                    icmp_cnt_reg <= icmp_cnt_reg + 16'd1;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status             <= ST_MISS;
            found_proto        <= 1'b0;
            found_addr         <= '0;
            found_inside_port  <= '0;
            found_outside_port <= '0;
            expired_count      <= '0;
            unique case (mode_reg)
                MODE_LKP_IN, MODE_LKP_OUT:
                begin
                    if (best_vld_reg)
                    begin
                        status             <= ST_HIT;
                        found_proto        <= best_ent_reg.proto;
                        found_addr         <= best_ent_reg.addr;
                        found_inside_port  <= best_ent_reg.iport;
                        found_outside_port <= best_ent_reg.oport;
                    end
                end
                MODE_INSERT:
                begin
                    if (free_vld_reg)
                    begin
                        status             <= ST_INSERTED;
                        found_proto        <= proto_reg;
                        found_addr         <= addr_reg;
                        found_inside_port  <= iport_reg;
                        found_outside_port <= new_oport;
                    end
                    else
                    begin
                        status <= ST_FULL;
                    end
                end
                MODE_TICK:
                begin
                    status        <= ST_TICK;
                    expired_count <= freed_reg;
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_ins_free: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |-> !valid_reg[free_idx_reg])
        else $error("insert into occupied slot");
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        do_hit |-> valid_reg[best_idx_reg])
        else $error("hit on invalid slot");
    a_ins_serial: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> serial_reg == $past(serial_reg) + 32'd1)
        else $error("serial not advanced");
`endif
endmodule

// ===== hw/rtl/nat_mapping_table_top.sv =====
// Top level of the NAT mapping table: APB registers, controller and datapath.
// Each transaction (lookup, insert or tick) scans every slot one per cycle
// through the registered-read entry RAM; after the scan, the last slot read
// is evaluated, then the result is loaded once the output register is free,
// and the next transaction can be accepted in the cycle after, since the scan
// over the single RAM read port allows one transaction at a time.
// The input stalls while a transaction is in progress. The result register
// holds the last result until taken. No clearing pass: slot validity resets
// at once. Registers at byte addresses 0,4,8,12: ICMP idle limit, TCP idle
// limit, ICMP port base, TCP port base; write only while idle.
module nat_mapping_table_top #(
    parameter int TABLE_DEPTH = nmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic        proto,
    input  logic [31:0] inside_addr,
    input  logic [15:0] inside_port,
    input  logic [15:0] outside_port,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        found_proto,
    output logic [31:0] found_addr,
    output logic [15:0] found_inside_port,
    output logic [15:0] found_outside_port,
    output logic [6:0]  expired_count
);
    import nmt_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;
    logic     cfg_we;
    logic [31:0] rdata;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = rdata;

    nmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    nmt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .mode               (mode),
        .proto              (proto),
        .inside_addr        (inside_addr),
        .inside_port        (inside_port),
        .outside_port       (outside_port),
        .cfg_we             (cfg_we),
        .cfg_idx            (paddr[3:2]),
        .cfg_data           (pwdata[15:0]),
        .cfg_rdata          (rdata),
        .status             (status),
        .found_proto        (found_proto),
        .found_addr         (found_addr),
        .found_inside_port  (found_inside_port),
        .found_outside_port (found_outside_port),
        .expired_count      (expired_count)
    );
endmodule
